/* hdl/canonical_kmer_stream_assert.svh */
// -----------------------------------------------------------------------------
// canonical_kmer_stream assertion macros
// Concurrent check shorthands, clocked and disabled during reset.
// -----------------------------------------------------------------------------
`ifndef CANONICAL_KMER_STREAM_ASSERT_SVH
`define CANONICAL_KMER_STREAM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CKS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define CKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

/* hdl/ckmer_pkg.sv */
// -----------------------------------------------------------------------------
// ckmer_pkg
// Shared types, constants and helper functions of the canonical k-mer stream.
// -----------------------------------------------------------------------------
`default_nettype none

package ckmer_pkg;

    localparam int KMER_W       = 64;
    localparam int K_W          = 6;
    localparam int PB_W         = 4;
    localparam int PIDX_W       = 10;
    localparam int BASE_W       = 3;
    localparam int RUN_W        = 6;
    localparam int SHAMT_W      = 7;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 10;
    localparam int BUCKET_COUNT = 1024;
    localparam int BUCKET_W     = $clog2(BUCKET_COUNT);

    localparam logic [K_W-1:0]    K_MAX      = 6'd32;
    localparam logic [K_W-1:0]    K_RESET    = 6'd31;
    localparam logic [PB_W-1:0]   PB_MAX     = 4'd10;
    localparam logic [RUN_W-1:0]  RUN_MAX    = 6'd32;
    localparam logic [BASE_W-1:0] BASE_T     = 3'd3;

    // Register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_KMER_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PASS_BITS   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PASS_INDEX  = 2'd2;

    typedef struct packed {
        logic              emit;
        logic [KMER_W-1:0] fw_sel;
        logic [KMER_W-1:0] rc_sel;
    } win_out_t;

    // Clamp k to 1..32
    function automatic logic [K_W-1:0] eff_k(input logic [K_W-1:0] k);
        logic [K_W-1:0] r;
        r = k;
        if (k == '0) r = 6'd1;
        else if (k > K_MAX) r = K_MAX;
        return r;
    endfunction

    // Clamp pass bits to 0..10
    function automatic logic [PB_W-1:0] eff_pb(input logic [PB_W-1:0] pb);
        return (pb > PB_MAX) ? PB_MAX : pb;
    endfunction

    // Right shift that drops everything outside the last k bases (2*k bits)
    function automatic logic [SHAMT_W-1:0] drop_bits(input logic [K_W-1:0] k);
        return SHAMT_W'(KMER_W) - {k, 1'b0};
    endfunction

endpackage

`default_nettype wire

/* hdl/canonical_kmer_stream.sv */
// -----------------------------------------------------------------------------
// canonical_kmer_stream
// Streams nucleotides in and emits canonical k-mers with pass flag and bucket.
// -----------------------------------------------------------------------------
// One base per transaction goes in; once k consecutive valid bases (no N since
// the last sequence start) have been seen, every further valid base produces
// one result transaction holding the canonical k-mer (the smaller of forward
// and reverse-complement 2-bit values of the last k bases), its bucket index
// and an in-pass flag. Bases of any code above T count as N: they end the run
// and produce nothing. The block takes one base per clock cycle while the
// result side keeps up; each result passes through the extract, compare and
// output stages. Every stage holds while the next one is full and stalled,
// so backpressure reaches s_tready only after all three stages fill.
// Configuration writes are applied at once and are meant for idle periods;
// a change of k takes effect on the next base without losing the window
// history.
// -----------------------------------------------------------------------------
`default_nettype none

`include "canonical_kmer_stream_assert.svh"

module canonical_kmer_stream
    import ckmer_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Base input stream
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [7:0]            s_tdata,   // [2:0] base_code, [7:3] zero
    input  wire logic                  s_tuser,   // [0] first_of_sequence
    // Result stream
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [79:0]           m_tdata,   // [63:0] canonical_kmer,
                                                  // [73:64] bucket, [79:74] zero
    output      logic                  m_tuser    // [0] in_pass
);

    // ---------------- configuration registers ----------------
    logic [K_W-1:0]    kmer_length_reg;
    logic [PB_W-1:0]   pass_bits_reg;
    logic [PIDX_W-1:0] pass_index_reg;
    logic [K_W-1:0]    k_eff;
    logic [PB_W-1:0]   pb_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_length_reg <= K_RESET;
            pass_bits_reg   <= '0;
            pass_index_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_KMER_LENGTH: kmer_length_reg <= cfg_data[K_W-1:0];
                REG_PASS_BITS:   pass_bits_reg   <= cfg_data[PB_W-1:0];
                REG_PASS_INDEX:  pass_index_reg  <= cfg_data[PIDX_W-1:0];
                default:         ; // unmapped index: drop the write
            endcase
        end
    end

    assign k_eff  = eff_k(kmer_length_reg);
    assign pb_eff = eff_pb(pass_bits_reg);

    // ---------------- pipeline handshake ----------------
    // Each stage advances when the stage behind it is empty or advancing.
    logic out_ready, s2_ready, s1_ready, take;
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic m_valid_reg,  m_valid_next;

    assign out_ready = !m_valid_reg  || m_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;
    assign take      = s_tvalid && s_tready;

    // ---------------- window and extraction ----------------
    win_out_t win_out;

    ckmer_window u_window (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .take              (take),
        .base_code         (s_tdata[BASE_W-1:0]),
        .first_of_sequence (s_tuser),
        .k_eff             (k_eff),
        .win_out           (win_out)
    );

    // ---------------- stage registers ----------------
    logic [KMER_W-1:0]   s1_fw_reg, s1_rc_reg;
    logic [KMER_W-1:0]   s2_canon_reg, s2_canon_next;
    logic [KMER_W-1:0]   m_canon_reg;
    logic [BUCKET_W-1:0] m_bucket_reg, bucket_next;
    logic                m_pass_reg, pass_next;
    logic [PIDX_W-1:0]   pass_mask;
    logic [19:0]         canon_low_shift;

    // Stage 1 fills only on a base that yields a result; otherwise drain.
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (take)          s1_valid_next = win_out.emit;
        else if (s2_ready) s1_valid_next = 1'b0;
    end

    always_comb begin
        s2_valid_next = s2_ready  ? s1_valid_reg : s2_valid_reg;
        m_valid_next  = out_ready ? s2_valid_reg : m_valid_reg;
    end

    // Numeric minimum matches string order since A<C<G<T
    assign s2_canon_next = (s1_fw_reg < s1_rc_reg) ? s1_fw_reg : s1_rc_reg;

    // Partition pass compare and bucket from the low bits of the canonical value
    assign pass_mask       = ~({PIDX_W{1'b1}} << pb_eff);
    assign pass_next       = ((s2_canon_reg[PIDX_W-1:0] & pass_mask) == pass_index_reg);
    assign canon_low_shift = s2_canon_reg[19:0] >> pb_eff;
    assign bucket_next     = canon_low_shift[BUCKET_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload: hold while the stage is stalled
    always_ff @(posedge aclk) begin
        if (take) begin
            s1_fw_reg <= win_out.fw_sel;
            s1_rc_reg <= win_out.rc_sel;
        end
        if (s2_ready) begin
            s2_canon_reg <= s2_canon_next;
        end
        if (out_ready) begin
            m_canon_reg  <= s2_canon_reg;
            m_bucket_reg <= bucket_next;
            m_pass_reg   <= pass_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_bucket_reg, m_canon_reg};
    assign m_tuser  = m_pass_reg;

    // ---------------- assertions ----------------
    logic [KMER_W-1:0] chk_mask;
    assign chk_mask = {KMER_W{1'b1}} >> drop_bits(k_eff);

    `CKS_ASSERT_SAME(a_full_stall_blocks_input, aclk, aresetn, s1_valid_reg && s2_valid_reg && m_valid_reg && !m_tready, !s_tready)
    `CKS_ASSERT_NEXT(a_s2_holds_on_stall, aclk, aresetn, s2_valid_reg && m_valid_reg && !m_tready, s2_valid_reg)
    `CKS_ASSERT_SAME(a_extract_width, aclk, aresetn, s1_valid_reg, ((s1_fw_reg | s1_rc_reg) & ~chk_mask) == '0)

endmodule

`default_nettype wire

/* hdl/ckmer_window.sv */
// -----------------------------------------------------------------------------
// ckmer_window
// Forward and reverse-complement base windows with run counter; extracts the
// last k bases of both strands for each accepted base.
// -----------------------------------------------------------------------------
`default_nettype none

module ckmer_window
    import ckmer_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              take,
    input  wire logic [BASE_W-1:0] base_code,
    input  wire logic              first_of_sequence,
    input  wire logic [K_W-1:0]    k_eff,
    output      win_out_t          win_out
);

    logic [KMER_W-1:0]  fw_reg, fw_next;
    logic [KMER_W-1:0]  rc_reg, rc_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic [KMER_W-1:0]  fw_shift, rc_shift, k_mask;
    logic [RUN_W-1:0]   run_start, run_inc;
    logic [SHAMT_W-1:0] shamt;
    logic               base_ok;

    assign base_ok   = (base_code <= BASE_T);
    // Newest base enters the low end forward and the high end reverse-complement
    assign fw_shift  = {fw_reg[KMER_W-3:0], base_code[1:0]};
    assign rc_shift  = {~base_code[1:0], rc_reg[KMER_W-1:2]};
    assign run_start = first_of_sequence ? '0 : run_reg;
    assign run_inc   = (run_start == RUN_MAX) ? RUN_MAX : run_start + 1'b1;

    assign shamt  = drop_bits(k_eff);
    assign k_mask = {KMER_W{1'b1}} >> shamt;

    always_comb begin
        fw_next  = fw_reg;
        rc_next  = rc_reg;
        run_next = run_reg;
        if (take) begin
            if (base_ok) begin
                fw_next  = fw_shift;
                rc_next  = rc_shift;
                run_next = run_inc;
            end else begin
                run_next = '0;
            end
        end
    end

    always_comb begin
        win_out.emit   = base_ok && (run_inc >= k_eff);
        win_out.fw_sel = fw_shift & k_mask;
        win_out.rc_sel = rc_shift >> shamt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg  <= '0;
            rc_reg  <= '0;
            run_reg <= '0;
        end else begin
            fw_reg  <= fw_next;
            rc_reg  <= rc_next;
            run_reg <= run_next;
        end
    end

endmodule

`default_nettype wire

/* verif/ckmer_checker.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ckmer_checker
// Watches the base and result streams of the canonical k-mer block, tracks
// the configuration writes, predicts every result and compares it in order.
// -----------------------------------------------------------------------------

module ckmer_checker
    import ckmer_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [7:0]            s_tdata,   // [2:0] base_code, [7:3] zero
    input  wire logic                  s_tuser,   // [0] first_of_sequence
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [79:0]           m_tdata,   // [63:0] canonical_kmer,
                                                  // [73:64] bucket, [79:74] zero
    input  wire logic                  m_tuser,   // [0] in_pass
    output int                         mismatch_count,
    output int                         kmers_pending,
    output int                         kmers_checked
);

    typedef struct packed {
        logic [KMER_W-1:0]   kmer;
        logic [BUCKET_W-1:0] bucket;
        logic                in_pass;
    } kmer_result_t;

    kmer_result_t expected_kmers[$];

    // Window copies: newest base low in fwd_bases, its complement high in rc_bases
    logic [KMER_W-1:0] fwd_bases;
    logic [KMER_W-1:0] rc_bases;
    int unsigned       run_len;

    logic [K_W-1:0]    k_cfg;
    logic [PB_W-1:0]   pb_cfg;
    logic [PIDX_W-1:0] pidx_cfg;

    // Take one base into the windows; report the canonical k-mer if the run is long enough
    task automatic shift_in_base(input logic [BASE_W-1:0] code, input logic restart,
                                 output bit emit, output kmer_result_t res);
        int unsigned       k;
        int unsigned       pb;
        logic [KMER_W-1:0] fw;
        logic [KMER_W-1:0] rc;
        logic [KMER_W-1:0] canon;
        logic [KMER_W-1:0] low_mask;
        emit = 1'b0;
        res  = '0;
        if (restart) run_len = 0;
        // N and any code above it end the run; the windows hold
        if (code > BASE_T) begin
            run_len = 0;
            return;
        end
        fwd_bases = {fwd_bases[KMER_W-3:0], code[1:0]};
        rc_bases  = {~code[1:0], rc_bases[KMER_W-1:2]};
        if (run_len < 32) run_len++;

        k = (k_cfg == 0) ? 1 : ((k_cfg > 32) ? 32 : k_cfg);
        if (run_len < k) return;
        if (k == 32) begin
            fw = fwd_bases;
            rc = rc_bases;
        end else begin
            fw = fwd_bases & ((64'd1 << (2 * k)) - 64'd1);
            rc = rc_bases >> (64 - 2 * k);
        end
        canon = (fw < rc) ? fw : rc;

        pb       = (pb_cfg > 10) ? 10 : pb_cfg;
        low_mask = (64'd1 << pb) - 64'd1;
        res.kmer    = canon;
        // all ten index bits take part, so an index past the pass count never matches
        res.in_pass = ((canon & low_mask) == KMER_W'(pidx_cfg));
        res.bucket  = BUCKET_W'(canon >> pb);
        emit = 1'b1;
    endtask

    always @(posedge aclk) begin : watch
        kmer_result_t got;
        kmer_result_t want;
        kmer_result_t next_res;
        bit           emit;
        if (!aresetn) begin
            fwd_bases = '0;
            rc_bases  = '0;
            run_len   = 0;
            k_cfg     = K_RESET;
            pb_cfg    = '0;
            pidx_cfg  = '0;
            expected_kmers.delete();
        end else begin
            // Compare the outgoing result first: it always stems from an earlier base
            if (m_tvalid && m_tready) begin
                got.kmer    = m_tdata[KMER_W-1:0];
                got.bucket  = m_tdata[KMER_W +: BUCKET_W];
                got.in_pass = m_tuser;
                if (expected_kmers.size() == 0) begin
                    $error("unexpected result transaction: canonical_kmer %h", got.kmer);
                    mismatch_count++;
                end else begin
                    want = expected_kmers.pop_front();
                    kmers_checked++;
                    if (got.kmer !== want.kmer) begin
                        $error("canonical_kmer: expected %h, actual %h", want.kmer, got.kmer);
                        mismatch_count++;
                    end
                    if (got.bucket !== want.bucket) begin
                        $error("bucket: expected %0d, actual %0d", want.bucket, got.bucket);
                        mismatch_count++;
                    end
                    if (got.in_pass !== want.in_pass) begin
                        $error("in_pass: expected %0b, actual %0b", want.in_pass, got.in_pass);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                shift_in_base(s_tdata[BASE_W-1:0], s_tuser, emit, next_res);
                if (emit) expected_kmers.push_back(next_res);
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_KMER_LENGTH: k_cfg    = cfg_data[K_W-1:0];
                    REG_PASS_BITS:   pb_cfg   = cfg_data[PB_W-1:0];
                    REG_PASS_INDEX:  pidx_cfg = cfg_data[PIDX_W-1:0];
                    default: ;
                endcase
            end
        end
        kmers_pending = expected_kmers.size();
    end

endmodule

/* verif/tb_canonical_kmer_stream.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_canonical_kmer_stream
// Drives nucleotide streams through the canonical k-mer block under a series
// of register settings, with random source gaps and sink stalls; a checker
// beside the block predicts and compares every result transaction.
// -----------------------------------------------------------------------------

module tb_canonical_kmer_stream
    import ckmer_pkg::*;
();

    // Nucleotide codes on s_tdata; every code above N also counts as N
    localparam logic [BASE_W-1:0] NT_A      = 3'd0;
    localparam logic [BASE_W-1:0] NT_C      = 3'd1;
    localparam logic [BASE_W-1:0] NT_G      = 3'd2;
    localparam logic [BASE_W-1:0] NT_T      = 3'd3;
    localparam logic [BASE_W-1:0] NT_N      = 3'd4;
    localparam logic [BASE_W-1:0] NT_BAD_LO = 3'd5;
    localparam logic [BASE_W-1:0] NT_BAD_HI = 3'd7;

    // Three pipeline stages; hold this long after the last result leaves
    // before touching registers.
    localparam int PIPE_SETTLE = 8;
    // Longest legal silence is a source gap plus a sink stall plus the
    // pipeline and a drain pause. Allow far more.
    localparam int STALL_LIMIT = 2000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [2:0] base_code, [7:3] zero
    logic                  s_tuser;   // [0] first_of_sequence
    logic                  m_tvalid;
    logic                  m_tready;
    logic [79:0]           m_tdata;   // [63:0] canonical_kmer, [73:64] bucket, [79:74] zero
    logic                  m_tuser;   // [0] in_pass

    int mismatch_count;
    int kmers_pending;
    int kmers_checked;

    bit src_gaps    = 1'b0;
    bit sink_stalls = 1'b0;
    int bases_sent    = 0;
    int settings_used = 0;
    int seq_left      = 0;
    int idle_cycles   = 0;

    canonical_kmer_stream uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ckmer_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .kmers_pending  (kmers_pending),
        .kmers_checked  (kmers_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Abort when neither channel moves a transaction for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, kmers_pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result sink: ready stretches broken by stall bursts while stalls are enabled;
    // a burst ends early once stalls are switched off
    initial begin : sink
        int stall_len;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (sink_stalls && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                stall_len = $urandom_range(1, 16);
                while (stall_len > 0 && sink_stalls) begin
                    @(posedge aclk);
                    stall_len--;
                end
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    // Offer one base and hold it until accepted. Sample s_tready at the falling
    // edge, where it is settled, and count the transaction at the next rising edge.
    task automatic send_base(input logic [BASE_W-1:0] code, input logic restart);
        logic rdy;
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, code};
        s_tuser  <= restart;
        forever begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
            if (rdy) break;
        end
        bases_sent++;
    endtask

    // Drop valid, wait for every predicted result, then let the pipeline empty
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (kmers_pending != 0);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    // Write all three registers on consecutive cycles; only called while idle
    task automatic apply_setting(input logic [K_W-1:0] k, input logic [PB_W-1:0] pb,
                                 input logic [PIDX_W-1:0] pidx);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_KMER_LENGTH;
        cfg_data <= CFG_DATA_W'(k);
        @(posedge aclk);
        cfg_addr <= REG_PASS_BITS;
        cfg_data <= CFG_DATA_W'(pb);
        @(posedge aclk);
        cfg_addr <= REG_PASS_INDEX;
        cfg_data <= CFG_DATA_W'(pidx);
        @(posedge aclk);
        cfg_we   <= 1'b0;
        settings_used++;
    endtask

    // Mostly clean sequences of random length with random content; the rest is
    // N bases, codes above N and stray restarts. A sequence may straddle phases,
    // so a k change mid-run also occurs.
    task automatic random_bases(input int count);
        logic [BASE_W-1:0] code;
        logic              restart;
        repeat (count) begin
            restart = 1'b0;
            if (seq_left == 0) begin
                seq_left = $urandom_range(1, 90);
                restart  = ($urandom_range(0, 7) != 0);
            end
            seq_left--;
            if ($urandom_range(0, 39) == 0) begin
                code = BASE_W'($urandom_range(NT_N, NT_BAD_HI));
            end else begin
                code = BASE_W'($urandom_range(NT_A, NT_T));
            end
            if ($urandom_range(0, 199) == 0) restart = 1'b1;
            send_base(code, restart);
            // occasionally hold the source until the result queue runs dry
            if (src_gaps && $urandom_range(0, 299) == 0) wait_for_results();
        end
    endtask

    task automatic run_phase(input logic [K_W-1:0] k, input logic [PB_W-1:0] pb,
                             input logic [PIDX_W-1:0] pidx, input int count,
                             input bit quiet);
        wait_for_results();
        apply_setting(k, pb, pidx);
        src_gaps    = !quiet && ($urandom_range(0, 3) != 0);
        sink_stalls = !quiet && ($urandom_range(0, 3) != 0);
        random_bases(count);
    endtask

    initial begin : stimulus
        aresetn  = 1'b0;
        cfg_we   = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: k = 3, two pass bits, pass index 1
        apply_setting(6'd3, 4'd2, 10'd1);
        send_base(NT_A, 1'b1);
        send_base(NT_C, 1'b0);
        send_base(NT_G, 1'b0);        // first 3-mer: ACG beats its complement CGT
        send_base(NT_T, 1'b0);        // CGT loses to its own complement ACG
        send_base(NT_N, 1'b0);        // N ends the run, windows hold
        send_base(NT_T, 1'b0);
        send_base(NT_T, 1'b0);
        send_base(NT_T, 1'b0);        // TTT: complement AAA is all zeros
        send_base(NT_BAD_LO, 1'b0);   // code above N acts as N
        send_base(NT_A, 1'b0);
        send_base(NT_A, 1'b0);
        send_base(NT_A, 1'b0);        // AAA forward
        send_base(NT_BAD_HI, 1'b0);   // all code bits set
        send_base(NT_G, 1'b0);
        send_base(NT_G, 1'b0);
        send_base(NT_G, 1'b0);        // GGG gives CCC
        send_base(NT_C, 1'b1);        // restart in the middle of a run
        send_base(NT_A, 1'b0);
        send_base(NT_T, 1'b0);        // CAT vs ATG
        send_base(NT_G, 1'b0);
        send_base(NT_N, 1'b1);        // restart flag on an N base
        wait_for_results();

        // Directed: k zero acts as 1, pass bits clamp to 10, index never matches
        apply_setting(6'd0, 4'd15, 10'd1023);
        send_base(NT_T, 1'b1);
        send_base(NT_G, 1'b0);
        send_base(NT_C, 1'b0);

        // Random phases across the register extremes
        run_phase(6'd1,  4'd0,  10'd0,    180, 1'b0);
        run_phase(6'd32, 4'd10, 10'd1023, 200, 1'b0);
        run_phase(6'd63, 4'd15, 10'd5,    180, 1'b0);   // k and pass bits above range
        run_phase(6'd33, 4'd11, 10'd700,  180, 1'b0);
        run_phase(6'd16, 4'd4,  10'd9,    180, 1'b0);
        run_phase(6'd2,  4'd3,  10'd12,   180, 1'b0);   // index past the pass count
        run_phase(6'd31, 4'd1,  10'd1,    180, 1'b0);
        run_phase(6'd0,  4'd0,  10'd0,    180, 1'b0);   // every k-mer in pass
        run_phase(6'd20, PB_W'($urandom_range(0, 10)), PIDX_W'($urandom_range(0, 15)),
                  180, 1'b0);
        // Closing stretch at full rate on both sides
        run_phase(6'd5,  4'd2,  10'd3,    200, 1'b1);

        wait_for_results();

        $display("Sent %0d bases under %0d register settings; compared %0d canonical k-mers.",
                 bases_sent, settings_used, kmers_checked);
        $display("Covered k from 1 to 32 with out-of-range values, N and invalid codes, restarts.");
        if (mismatch_count == 0 && kmers_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
